### rtl/core/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and codes for the LIFO stack with peek
// Operation codes, status codes and the control word driven into the cells.
// ----------------------------------------------------------------------------
package lsp_pkg;

  // operation codes carried on func
  localparam logic [2:0] FUNC_PUSH   = 3'd0;
  localparam logic [2:0] FUNC_POP    = 3'd1;
  localparam logic [2:0] FUNC_PEEK   = 3'd2;
  localparam logic [2:0] FUNC_TOP    = 3'd3;
  localparam logic [2:0] FUNC_BOTTOM = 3'd4;

  // status codes returned with each result word
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

  // capacity register
  localparam int unsigned CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // word width
  localparam int unsigned WORD_W = 32;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_dn;    // push: every entry moves one cell away from the top
    logic shift_up;    // pop: every entry moves one cell toward the top
    logic lane_load;   // copy entries into the read lane
    logic lane_shift;  // move the read lane one cell toward the top
  } cell_ctrl_t;

endpackage

### rtl/core/lsp_cell.sv
// ----------------------------------------------------------------------------
// lsp_cell: one stack position
// Holds one entry and one read-lane word; trades both with its neighbors.
// ----------------------------------------------------------------------------
module lsp_cell (
  input  logic                                 clk_i,
  input  lsp_pkg::cell_ctrl_t                  ctrl_i,
  input  logic signed [lsp_pkg::WORD_W-1:0]    prev_data_i,
  input  logic signed [lsp_pkg::WORD_W-1:0]    next_data_i,
  input  logic signed [lsp_pkg::WORD_W-1:0]    next_lane_i,
  output logic signed [lsp_pkg::WORD_W-1:0]    data_o,
  output logic signed [lsp_pkg::WORD_W-1:0]    lane_o
);

  logic signed [lsp_pkg::WORD_W-1:0] entry_q, entry_d;
  logic signed [lsp_pkg::WORD_W-1:0] lane_q, lane_d;

  // take the word from the upper neighbor on push, the lower one on pop
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_dn) begin
      entry_d = prev_data_i;
    end else if (ctrl_i.shift_up) begin
      entry_d = next_data_i;
    end
  end

  // load the lane from the entry, or advance it toward the top
  always_comb begin
    lane_d = lane_q;
    if (ctrl_i.lane_load) begin
      lane_d = entry_q;
    end else if (ctrl_i.lane_shift) begin
      lane_d = next_lane_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    lane_q  <= lane_d;
  end

  assign data_o = entry_q;
  assign lane_o = lane_q;

endmodule

### rtl/core/lsp_ctrl.sv
// ----------------------------------------------------------------------------
// lsp_ctrl: stack controller
// Decodes commands, keeps the entry count, capacity and bottom word, steers
// the cell chain and registers one result word per command.
// ----------------------------------------------------------------------------
module lsp_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         func_i,
  input  logic signed [lsp_pkg::WORD_W-1:0]  push_value_i,
  input  logic [6:0]                         peek_depth_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lsp_pkg::CAP_W-1:0]          cfg_data_i,
  input  logic signed [lsp_pkg::WORD_W-1:0]  top_data_i,
  input  logic signed [lsp_pkg::WORD_W-1:0]  lane_top_i,
  output lsp_pkg::cell_ctrl_t                cell_ctrl_o,
  output logic                               result_valid_o,
  output logic signed [lsp_pkg::WORD_W-1:0]  read_data_o,
  output logic [1:0]                         status_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > lsp_pkg::CAP_W) ? CNT_W : lsp_pkg::CAP_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PEEK = 1'b1;

  logic                              state_q, state_d;
  logic [CNT_W-1:0]                  count_q, count_d;
  logic [CNT_W-1:0]                  rem_q, rem_d;
  logic [lsp_pkg::CAP_W-1:0]         cap_q;
  logic signed [lsp_pkg::WORD_W-1:0] bottom_q, bottom_d;

  logic                              res_valid_q, res_valid_d;
  logic signed [lsp_pkg::WORD_W-1:0] res_data_q, res_data_d;
  logic [1:0]                        res_status_q, res_status_d;
  logic                              res_empty_q, res_empty_d;
  logic                              res_full_q, res_full_d;

  logic [CMP_W-1:0] cap_ext, depth_ext, eff_cap, count_ext, count_d_ext, peek_ext;
  logic             accept, full_now, empty_now, peek_ok;

  assign accept      = start && (state_q == ST_IDLE);
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // saturate capacity to the physical depth
  assign cap_ext   = CMP_W'(cap_q);
  assign depth_ext = CMP_W'(DEPTH);
  assign eff_cap   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign count_ext = CMP_W'(count_q);
  assign peek_ext  = CMP_W'(peek_depth_i);
  assign full_now  = (count_ext >= eff_cap);
  assign empty_now = (count_q == '0);
  assign peek_ok   = (peek_depth_i != '0) && (peek_ext <= count_ext);

  assign count_d_ext = CMP_W'(count_d);

  // decode the command and sequence the peek lane
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rem_d        = rem_q;
    bottom_d     = bottom_q;
    cell_ctrl_o  = '0;
    res_valid_d  = 1'b0;
    res_data_d   = '0;
    res_status_d = lsp_pkg::STAT_OK;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          case (func_i)
            lsp_pkg::FUNC_PUSH: begin
              if (full_now) begin
                res_status_d = lsp_pkg::STAT_OVERFLOW;
              end else begin
                cell_ctrl_o.shift_dn = 1'b1;
                count_d              = count_q + 1'b1;
                if (empty_now) begin
                  bottom_d = push_value_i;
                end
              end
            end
            lsp_pkg::FUNC_POP: begin
              if (empty_now) begin
                res_status_d = lsp_pkg::STAT_UNDERFLOW;
              end else begin
                cell_ctrl_o.shift_up = 1'b1;
                count_d              = count_q - 1'b1;
                res_data_d           = top_data_i;
              end
            end
            lsp_pkg::FUNC_PEEK: begin
              if (peek_ok) begin
                res_valid_d           = 1'b0;
                cell_ctrl_o.lane_load = 1'b1;
                rem_d                 = CNT_W'(peek_ext - 1'b1);
                state_d               = ST_PEEK;
              end else begin
                res_status_d = lsp_pkg::STAT_BAD_INDEX;
              end
            end
            lsp_pkg::FUNC_TOP: begin
              if (empty_now) begin
                res_status_d = lsp_pkg::STAT_UNDERFLOW;
              end else begin
                res_data_d = top_data_i;
              end
            end
            lsp_pkg::FUNC_BOTTOM: begin
              if (empty_now) begin
                res_status_d = lsp_pkg::STAT_UNDERFLOW;
              end else begin
                res_data_d = bottom_q;
              end
            end
            default: begin
              res_status_d = lsp_pkg::STAT_BAD_INDEX;
            end
          endcase
        end
      end
      ST_PEEK: begin
        // advance the lane until the wanted word sits in the top cell
        if (rem_q == '0) begin
          res_valid_d = 1'b1;
          res_data_d  = lane_top_i;
          state_d     = ST_IDLE;
        end else begin
          cell_ctrl_o.lane_shift = 1'b1;
          rem_d                  = rem_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_empty_d = (count_d == '0);
    res_full_d  = (count_d_ext >= eff_cap);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cap_q       <= lsp_pkg::CAP_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // hold payload
  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    bottom_q     <= bottom_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    res_empty_q  <= res_empty_d;
    res_full_q   <= res_full_d;
  end

  assign result_valid_o = res_valid_q;
  assign read_data_o    = res_data_q;
  assign status_o       = res_status_q;
  assign is_empty_o     = res_empty_q;
  assign is_full_o      = res_full_q;

  // no result while the lane is still moving
  a_peek_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PEEK && rem_q != '0) |=> !res_valid_q)
    else $error("result raised during peek shifting");

  // every command other than a valid peek answers in the next cycle
  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !(func_i == lsp_pkg::FUNC_PEEK && peek_ok)) |=> res_valid_q)
    else $error("command produced no result");

  // count stays within the chain
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_ext <= depth_ext)
    else $error("entry count beyond depth");

  // a failed command returns zero data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_status_q != lsp_pkg::STAT_OK) |-> (res_data_q == '0))
    else $error("nonzero data on failed command");

  // a successful push adds one entry
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == lsp_pkg::FUNC_PUSH && !full_now)
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("push did not advance count");

endmodule

### rtl/core/lifo_stack_with_peek_unit.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_peek_unit: LIFO stack of signed words with peek
// A chain of DEPTH cells holds the stack with the top word in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/func_i/push_value_i/peek_depth_i and are taken
//   at a clock edge with start high and busy low. Each command returns one
//   word on read_data_o/status_o/is_empty_o/is_full_o, marked by a one-cycle
//   result_valid_o strobe; the receiver cannot stall and must take it then.
//   Push, pop, read top and read bottom answer in the cycle after
//   acceptance and the next command may enter in that same cycle, one
//   command per cycle sustained. Push and pop shift the whole cell chain
//   by one position; the bottom word is kept in its own register.
//   A valid peek at position n copies the chain into a read lane that moves
//   one cell toward the top each cycle; busy stays high until the wanted
//   word is registered from the top cell. Failed commands answer as push and pop do.
//   The capacity register is written over cfg_valid_i/cfg_data_i, always
//   ready; write it only while no command is in flight.
//   Reset empties the stack and sets capacity to 64; cell contents are not
//   cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
module lifo_stack_with_peek_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         func_i,
  input  logic signed [lsp_pkg::WORD_W-1:0]  push_value_i,
  input  logic [6:0]                         peek_depth_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lsp_pkg::CAP_W-1:0]          cfg_data_i,
  output logic                               result_valid_o,
  output logic signed [lsp_pkg::WORD_W-1:0]  read_data_o,
  output logic [1:0]                         status_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);

  lsp_pkg::cell_ctrl_t cell_ctrl;
  logic signed [lsp_pkg::WORD_W-1:0] cell_data [DEPTH];
  logic signed [lsp_pkg::WORD_W-1:0] cell_lane [DEPTH];

  lsp_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .push_value_i   (push_value_i),
    .peek_depth_i   (peek_depth_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .top_data_i     (cell_data[0]),
    .lane_top_i     (cell_lane[0]),
    .cell_ctrl_o    (cell_ctrl),
    .result_valid_o (result_valid_o),
    .read_data_o    (read_data_o),
    .status_o       (status_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

  // build the chain: cell 0 takes pushed words, the last cell reads zero below
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [lsp_pkg::WORD_W-1:0] prev_data, next_data, next_lane;

    if (i == 0) begin : g_head
      assign prev_data = push_value_i;
    end else begin : g_body
      assign prev_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_data = '0;
      assign next_lane = '0;
    end else begin : g_link
      assign next_data = cell_data[i+1];
      assign next_lane = cell_lane[i+1];
    end

    lsp_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .next_lane_i (next_lane),
      .data_o      (cell_data[i]),
      .lane_o      (cell_lane[i])
    );
  end

endmodule

### test/lifo_stack_peek_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_peek_checker: result checker for the LIFO stack with peek
// Watches the command, capacity and result channels, keeps its own copy of
// the stack and the capacity, predicts one reply word per accepted command
// and compares each result strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module lifo_stack_peek_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_start_i,
  input  logic                              cmd_busy_i,
  input  logic [2:0]                        cmd_func_i,
  input  logic signed [lsp_pkg::WORD_W-1:0] cmd_value_i,
  input  logic [6:0]                        cmd_pos_i,
  input  logic                              cap_valid_i,
  input  logic                              cap_ready_i,
  input  logic [lsp_pkg::CAP_W-1:0]         cap_data_i,
  input  logic                              res_valid_i,
  input  logic signed [lsp_pkg::WORD_W-1:0] res_data_i,
  input  logic [1:0]                        res_status_i,
  input  logic                              res_empty_i,
  input  logic                              res_full_i,
  output int                                mismatch_count_o,
  output int                                pending_o
);

  typedef struct packed {
    logic signed [lsp_pkg::WORD_W-1:0] data;
    logic [1:0]                        status;
    logic                              empty;
    logic                              full;
  } stack_reply_t;

  // shadow copy of the stack
  logic signed [lsp_pkg::WORD_W-1:0] shadow_store [DEPTH];
  int unsigned                       shadow_used;
  logic [lsp_pkg::CAP_W-1:0]         shadow_cap;
  stack_reply_t                      reply_q [$];
  int                                mismatches;

  // apply one command to the shadow stack and return the reply it causes
  function automatic stack_reply_t apply_command(input logic [2:0] op,
                                                 input logic signed [lsp_pkg::WORD_W-1:0] word,
                                                 input logic [6:0] pos);
    stack_reply_t r;
    int unsigned  lim;
    lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    r = '0;
    r.status = lsp_pkg::STAT_OK;
    case (op)
      lsp_pkg::FUNC_PUSH: begin
        if (shadow_used >= lim) begin
          r.status = lsp_pkg::STAT_OVERFLOW;
        end else begin
          shadow_store[shadow_used] = word;
          shadow_used++;
        end
      end
      lsp_pkg::FUNC_POP: begin
        if (shadow_used == 0) begin
          r.status = lsp_pkg::STAT_UNDERFLOW;
        end else begin
          shadow_used--;
          r.data = shadow_store[shadow_used];
        end
      end
      lsp_pkg::FUNC_PEEK: begin
        if (pos == 0 || pos > shadow_used) begin
          r.status = lsp_pkg::STAT_BAD_INDEX;
        end else begin
          r.data = shadow_store[shadow_used - pos];
        end
      end
      lsp_pkg::FUNC_TOP: begin
        if (shadow_used == 0) r.status = lsp_pkg::STAT_UNDERFLOW;
        else r.data = shadow_store[shadow_used - 1];
      end
      lsp_pkg::FUNC_BOTTOM: begin
        if (shadow_used == 0) r.status = lsp_pkg::STAT_UNDERFLOW;
        else r.data = shadow_store[0];
      end
      default: r.status = lsp_pkg::STAT_BAD_INDEX;
    endcase
    if (r.status != lsp_pkg::STAT_OK) r.data = '0;
    r.empty = (shadow_used == 0);
    r.full  = (shadow_used >= lim);
    return r;
  endfunction

  // compare one result word against its prediction
  task automatic compare_reply(input stack_reply_t exp_r);
    if (res_data_i !== exp_r.data) begin
      $error("read_data: expected %0d, got %0d", exp_r.data, res_data_i);
      mismatches++;
    end
    if (res_status_i !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, res_status_i);
      mismatches++;
    end
    if (res_empty_i !== exp_r.empty) begin
      $error("is_empty: expected %0d, got %0d", exp_r.empty, res_empty_i);
      mismatches++;
    end
    if (res_full_i !== exp_r.full) begin
      $error("is_full: expected %0d, got %0d", exp_r.full, res_full_i);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_used = 0;
      shadow_cap  = lsp_pkg::CAP_RESET;
      reply_q.delete();
      mismatches  = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      // check the result word leaving this cycle
      if (res_valid_i) begin
        if (reply_q.size() == 0) begin
          $error("result word with no pending command: data %0d status %0d",
                 res_data_i, res_status_i);
          mismatches++;
        end else begin
          compare_reply(reply_q.pop_front());
        end
      end
      // take a capacity write
      if (cap_valid_i && cap_ready_i) shadow_cap = cap_data_i;
      // predict the reply of an accepted command
      if (cmd_start_i && !cmd_busy_i) begin
        reply_q.push_back(apply_command(cmd_func_i, cmd_value_i, cmd_pos_i));
      end
      pending_o        <= reply_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

### test/tb_lifo_stack_with_peek_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_peek_unit: testbench for the LIFO stack with peek
// Drives directed corner commands, then segments of random push/pop/peek/
// read traffic under changing capacity and sender idling; a checker module
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_peek_unit;

  localparam int unsigned DEPTH    = 64;
  localparam int          SEGMENTS = 13;
  localparam int          SEG_LEN  = 100;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic [2:0]                        func_i;
  logic signed [lsp_pkg::WORD_W-1:0] push_value_i;
  logic [6:0]                        peek_depth_i;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [lsp_pkg::CAP_W-1:0]         cfg_data_i;
  logic                              result_valid_o;
  logic signed [lsp_pkg::WORD_W-1:0] read_data_o;
  logic [1:0]                        status_o;
  logic                              is_empty_o;
  logic                              is_full_o;
  int                                mismatch_count;
  int                                pending;
  int                                sender_idle_pct;

  lifo_stack_with_peek_unit #(.DEPTH(DEPTH)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .push_value_i   (push_value_i),
    .peek_depth_i   (peek_depth_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .read_data_o    (read_data_o),
    .status_o       (status_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

  lifo_stack_peek_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_start_i      (start),
    .cmd_busy_i       (busy),
    .cmd_func_i       (func_i),
    .cmd_value_i      (push_value_i),
    .cmd_pos_i        (peek_depth_i),
    .cap_valid_i      (cfg_valid_i),
    .cap_ready_i      (cfg_ready_o),
    .cap_data_i       (cfg_data_i),
    .res_valid_i      (result_valid_o),
    .res_data_i       (read_data_o),
    .res_status_i     (status_o),
    .res_empty_i      (is_empty_o),
    .res_full_i       (is_full_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // clock: 4 ns period
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // send one command word, idling first at the current rate
  task automatic send_command(input logic [2:0] op,
                              input logic signed [lsp_pkg::WORD_W-1:0] word,
                              input logic [6:0] pos);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start        <= 1'b1;
    func_i       <= op;
    push_value_i <= word;
    peek_depth_i <= pos;
    do @(posedge clk_i); while (busy);
  endtask

  // hold off until every pending result word has come
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  // write the capacity register; only called with the block idle
  task automatic write_capacity(input logic [lsp_pkg::CAP_W-1:0] cap);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // push data: mostly random, sometimes an extreme
  function automatic logic signed [lsp_pkg::WORD_W-1:0] pick_word();
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return '0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // peek position: mostly near the top, sometimes anywhere or zero
  function automatic logic [6:0] pick_pos();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 7'($urandom_range(1, 8));
    if (r < 92) return 7'($urandom_range(0, DEPTH));
    return '0;
  endfunction

  // operation mix with the given push and pop shares in percent
  function automatic logic [2:0] pick_op(input int unsigned push_pct, input int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return lsp_pkg::FUNC_BOTTOM + 3'($urandom_range(1, 3));
    if (r < 3 + push_pct) return lsp_pkg::FUNC_PUSH;
    if (r < 3 + push_pct + pop_pct) return lsp_pkg::FUNC_POP;
    case ($urandom_range(0, 3))
      0, 1: return lsp_pkg::FUNC_PEEK;
      2: return lsp_pkg::FUNC_TOP;
      default: return lsp_pkg::FUNC_BOTTOM;
    endcase
  endfunction

  initial begin
    logic [lsp_pkg::CAP_W-1:0] seg_cap [SEGMENTS];
    logic                      seg_fill;
    start           = 1'b0;
    func_i          = lsp_pkg::FUNC_PUSH;
    push_value_i    = '0;
    peek_depth_i    = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = lsp_pkg::CAP_RESET;
    sender_idle_pct = 0;
    rst_ni          = 1'b0;
    seg_cap = '{7'd127, 7'd64, 7'd3, 7'd0, 7'd64, 7'd1, 7'd40, 7'd2, 7'd17,
                7'd64, 7'd64, 7'd5, 7'd64};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty-stack reads and bad peek positions
    send_command(lsp_pkg::FUNC_TOP, pick_word(), 7'd0);
    send_command(lsp_pkg::FUNC_POP, pick_word(), 7'd0);
    send_command(lsp_pkg::FUNC_BOTTOM, pick_word(), 7'd0);
    send_command(lsp_pkg::FUNC_PEEK, pick_word(), 7'd1);
    send_command(lsp_pkg::FUNC_PEEK, pick_word(), 7'd0);
    // extreme words
    send_command(lsp_pkg::FUNC_PUSH, 32'sh7FFF_FFFF, 7'd0);
    send_command(lsp_pkg::FUNC_PUSH, 32'sh8000_0000, 7'd64);
    send_command(lsp_pkg::FUNC_PUSH, -32'sd1, 7'd0);
    send_command(lsp_pkg::FUNC_PUSH, 32'sd0, 7'd0);
    send_command(lsp_pkg::FUNC_PUSH, 32'sh5A5A_A5A5, 7'd0);
    send_command(lsp_pkg::FUNC_TOP, '0, 7'd0);
    send_command(lsp_pkg::FUNC_BOTTOM, '0, 7'd0);
    send_command(lsp_pkg::FUNC_PEEK, '0, 7'd1);
    send_command(lsp_pkg::FUNC_PEEK, '0, 7'd5);
    send_command(lsp_pkg::FUNC_PEEK, '0, 7'd6);
    send_command(lsp_pkg::FUNC_PEEK, '0, 7'd0);
    send_command(lsp_pkg::FUNC_PEEK, '0, 7'd64);
    // unknown operations
    send_command(lsp_pkg::FUNC_BOTTOM + 3'd1, 32'sh1234_5678, 7'd1);
    send_command(lsp_pkg::FUNC_BOTTOM + 3'd2, '0, 7'd1);
    send_command(lsp_pkg::FUNC_BOTTOM + 3'd3, '0, 7'd1);
    send_command(lsp_pkg::FUNC_POP, '0, 7'd0);

    // random segments: fill or drain bias per segment under changing capacity
    for (int s = 0; s < SEGMENTS; s++) begin
      write_capacity(seg_cap[s]);
      sender_idle_pct = (s < 5) ? 13 : (s < 9) ? 59 : 0;
      seg_fill = (s inside {0, 1, 5, 6, 8, 9, 10});
      for (int i = 0; i < SEG_LEN; i++) begin
        if (seg_fill) send_command(pick_op(65, 10), pick_word(), pick_pos());
        else send_command(pick_op(15, 50), pick_word(), pick_pos());
      end
    end

    // wrap up
    drain_results();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lsp_pkg.sv
rtl/core/lsp_cell.sv
rtl/core/lsp_ctrl.sv
rtl/core/lifo_stack_with_peek_unit.sv
test/lifo_stack_peek_checker.sv
test/tb_lifo_stack_with_peek_unit.sv
